// ===== sv/nafh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nafh_pkg
// Types, codes and constants shared by the node address hash unit.
// ----------------------------------------------------------------------------
package nafh_pkg;

   // Hash constants
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_TOPBIT    = 16'h8000;
   localparam logic [15:0] FNV_MULT      = 16'h0193;
   localparam logic [15:0] FNV_BASIS     = 16'h2B4C;

   // Reserved addresses and their replacements
   localparam logic [15:0] ADDR_LOW_RSV  = 16'h0000;
   localparam logic [15:0] ADDR_HIGH_RSV = 16'hFFFF;
   localparam logic [15:0] ADDR_LOW_OK   = 16'h0001;
   localparam logic [15:0] ADDR_HIGH_OK  = 16'hFFFE;

   // Register file
   localparam int unsigned PADDR_W = 4;
   localparam logic [1:0] REG_USE_ID_HASH    = 2'd0;
   localparam logic [1:0] REG_REMAP_RESERVED = 2'd1;
   localparam logic [1:0] REG_RESULT_MASK    = 2'd2;

   localparam logic        USE_ID_HASH_RST    = 1'b1;
   localparam logic        REMAP_RESERVED_RST = 1'b1;
   localparam logic [15:0] RESULT_MASK_RST    = 16'hFFFF;

   typedef struct packed {
      logic [7:0] id_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] node_address;
      logic        fallback_needed;
      logic [15:0] crc_result;
      logic [15:0] fnv_result;
   } rsp_type;

   typedef struct packed {
      logic        use_id_hash;
      logic        remap_reserved;
      logic [15:0] result_mask;
   } cfg_type;

   typedef struct packed {
      logic [15:0] crc;
      logic [15:0] fnv;
   } hash_type;

endpackage
`default_nettype wire

// ===== sv/node_address_from_id_hash_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// node_address_from_id_hash_unit
// Hashes hardware-ID bytes into a node address (CRC-16 xor FNV-1a, masked).
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_data (id_byte, last_byte)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (address, flag, hashes)
//  csr     | in        | psel/penable/pready   | paddr, pwdata, prdata
//
//  One byte is accepted per cycle except while a last byte is held (below);
//  a request is held in the input register, and a non-last byte's hash
//  update reaches the accumulators as it leaves that register. A last byte
//  instead writes its result to the output register as it leaves.
//  Reset is synchronous and restores both hashes, the valid flags and settings.
//  A last byte holds in the input register only while the output register
//  is full and not taken; other bytes never stall.
// ----------------------------------------------------------------------------
module node_address_from_id_hash_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire nafh_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output nafh_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [nafh_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   nafh_pkg::cfg_type  cfg;
   nafh_pkg::req_type  in_data_ff;
   logic               in_valid_ff;
   nafh_pkg::hash_type acc_ff;
   nafh_pkg::hash_type acc_in;
   nafh_pkg::hash_type acc_next;
   nafh_pkg::rsp_type  out_data_ff;
   nafh_pkg::rsp_type  out_data_in;
   logic               out_valid_ff;
   logic               out_free;
   logic               advance;
   logic [15:0]        addr_masked;
   logic [15:0]        addr_fixed;

   nafh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   nafh_hash_step u_step (
      .id_byte  (in_data_ff.id_byte),
      .acc      (acc_ff),
      .acc_next (acc_next)
   );

   // Handshake: advance the held byte unless it needs a busy output slot
   assign out_free  = ~out_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & (~in_data_ff.last_byte | out_free);
   assign req_ready = ~in_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Accumulators restart after the last byte
   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         if (in_data_ff.last_byte) begin
            acc_in.crc = nafh_pkg::CRC_INIT;
            acc_in.fnv = nafh_pkg::FNV_BASIS;
         end else begin
            acc_in = acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff.crc <= nafh_pkg::CRC_INIT;
         acc_ff.fnv <= nafh_pkg::FNV_BASIS;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Form the address and remap reserved values
   assign addr_masked = (acc_next.crc ^ acc_next.fnv) & cfg.result_mask;

   always_comb begin
      addr_fixed = addr_masked;
      if (cfg.remap_reserved) begin
         if (addr_masked == nafh_pkg::ADDR_LOW_RSV) begin
            addr_fixed = nafh_pkg::ADDR_LOW_OK;
         end else if (addr_masked == nafh_pkg::ADDR_HIGH_RSV) begin
            addr_fixed = nafh_pkg::ADDR_HIGH_OK;
         end
      end
   end

   always_comb begin
      if (cfg.use_id_hash) begin
         out_data_in.node_address    = addr_fixed;
         out_data_in.fallback_needed = 1'b0;
         out_data_in.crc_result      = acc_next.crc;
         out_data_in.fnv_result      = acc_next.fnv;
      end else begin
         out_data_in.node_address    = 16'd0;
         out_data_in.fallback_needed = 1'b1;
         out_data_in.crc_result      = 16'd0;
         out_data_in.fnv_result      = 16'd0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_data_ff.last_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_data_ff.last_byte) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_data_ff.last_byte && out_valid_ff && !rsp_ready)
         |-> !req_ready)
      else $error("last byte accepted over a full output register");

   a_fallback_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fallback_needed)
         |-> (rsp_data.node_address == 16'd0 && rsp_data.crc_result == 16'd0
              && rsp_data.fnv_result == 16'd0))
      else $error("fallback result carries nonzero fields");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.last_byte)
         |=> (acc_ff.crc == nafh_pkg::CRC_INIT && acc_ff.fnv == nafh_pkg::FNV_BASIS))
      else $error("hashes not restarted after last byte");

   a_reset_acc: assert property (@(posedge clock)
      $past(reset) |-> (acc_ff.crc == nafh_pkg::CRC_INIT && !out_valid_ff))
      else $error("state not cleared by reset");

endmodule
`default_nettype wire

// ===== sv/nafh_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nafh_csr
// APB-style register file holding the hash unit configuration.
// ----------------------------------------------------------------------------
module nafh_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [nafh_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output nafh_pkg::cfg_type                  cfg
);

   logic        use_id_hash_ff;
   logic        remap_reserved_ff;
   logic [15:0] result_mask_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite & pready;

   // Write registers on the access cycle; other indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         use_id_hash_ff    <= nafh_pkg::USE_ID_HASH_RST;
         remap_reserved_ff <= nafh_pkg::REMAP_RESERVED_RST;
         result_mask_ff    <= nafh_pkg::RESULT_MASK_RST;
      end else if (wr_en) begin
         case (reg_idx)
            nafh_pkg::REG_USE_ID_HASH:    use_id_hash_ff    <= pwdata[0];
            nafh_pkg::REG_REMAP_RESERVED: remap_reserved_ff <= pwdata[0];
            nafh_pkg::REG_RESULT_MASK:    result_mask_ff    <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         nafh_pkg::REG_USE_ID_HASH:    prdata = {31'd0, use_id_hash_ff};
         nafh_pkg::REG_REMAP_RESERVED: prdata = {31'd0, remap_reserved_ff};
         nafh_pkg::REG_RESULT_MASK:    prdata = {16'd0, result_mask_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   assign cfg.use_id_hash    = use_id_hash_ff;
   assign cfg.remap_reserved = remap_reserved_ff;
   assign cfg.result_mask    = result_mask_ff;

endmodule
`default_nettype wire

// ===== sv/nafh_hash_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nafh_hash_step
// One-byte update of the CRC-16-CCITT and 16-bit FNV-1a running hashes.
// ----------------------------------------------------------------------------
module nafh_hash_step (
   input  wire logic [7:0]         id_byte,
   input  wire nafh_pkg::hash_type acc,
   output nafh_pkg::hash_type      acc_next
);

   logic [15:0] crc_v;
   logic [15:0] fnv_x;
   logic [31:0] fnv_prod;

   // Fold the byte in MSB first, eight shift steps of XOR logic
   always_comb begin
      crc_v = acc.crc ^ {id_byte, 8'd0};
      for (int i = 0; i < 8; i++) begin
         if ((crc_v & nafh_pkg::CRC_TOPBIT) != 16'd0) begin
            crc_v = {crc_v[14:0], 1'b0} ^ nafh_pkg::CRC_POLY;
         end else begin
            crc_v = {crc_v[14:0], 1'b0};
         end
      end
   end

   // XOR then multiply by the prime, keep the low half
   assign fnv_x    = acc.fnv ^ {8'd0, id_byte};
   assign fnv_prod = {16'd0, fnv_x} * {16'd0, nafh_pkg::FNV_MULT};

   assign acc_next.crc = crc_v;
   assign acc_next.fnv = fnv_prod[15:0];

endmodule
`default_nettype wire
